### design/csds_pkg.sv
// Shared types and constants for the C-SCAN disk scheduler.
package csds_pkg;

  localparam int CYL_W     = 16;
  localparam int MOVE_W    = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UPWARD   = 2'd2;

  localparam logic [CYL_W-1:0] DISK_SIZE_RST = 16'd200;
  localparam logic [CYL_W-1:0] START_POS_RST = 16'd0;
  localparam logic             SWEEP_UP_RST  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [CYL_W-1:0] val;
  } cell_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROT_LEFT,
    CELL_ROT_RIGHT,
    CELL_CLEAR
  } cell_op_t;

endpackage

### design/csds_cell.sv
// One cell of the sorting chain: holds one request, inserts or rotates.
module csds_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csds_pkg::cell_op_t            op_i,
  input  logic [csds_pkg::CYL_W-1:0]    new_val_i,
  input  csds_pkg::cell_t               ins_prev_i,
  input  logic                          ins_prev_lt_i,
  input  csds_pkg::cell_t               left_i,
  input  csds_pkg::cell_t               right_i,
  output csds_pkg::cell_t               cell_o,
  output logic                          lt_o
);

  logic                       valid_r, valid_nxt;
  logic [csds_pkg::CYL_W-1:0] val_r, val_nxt;

  // incoming value sorts ahead of the one held here
  assign lt_o = valid_r && (new_val_i < val_r);
  assign cell_o.valid = valid_r;
  assign cell_o.val   = val_r;

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    case (op_i)
      csds_pkg::CELL_INSERT: begin
        if (ins_prev_lt_i) begin
          // make room: take the neighbor's value that is pushed along
          valid_nxt = 1'b1;
          val_nxt   = ins_prev_i.val;
        end else if (ins_prev_i.valid && (!valid_r || lt_o)) begin
          valid_nxt = 1'b1;
          val_nxt   = new_val_i;
        end
      end
      csds_pkg::CELL_ROT_LEFT: begin
        valid_nxt = right_i.valid;
        val_nxt   = right_i.val;
      end
      csds_pkg::CELL_ROT_RIGHT: begin
        valid_nxt = left_i.valid;
        val_nxt   = left_i.val;
      end
      csds_pkg::CELL_CLEAR: begin
        valid_nxt = 1'b0;
      end
      csds_pkg::CELL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### design/circular_scan_disk_scheduler_core.sv
// Top level of the C-SCAN disk scheduler: sorting chain, sweep control, output register.
//
//   channel | direction | ports                                         | beat
//   --------+-----------+-----------------------------------------------+---------------------
//   in      | in        | in_valid/in_ready, in_request_cylinder,       | one request
//           |           | in_final_request                              |
//   out     | out       | out_valid/out_ready, out_visited_cylinder,    | one head visit
//           |           | out_movement_so_far, out_schedule_done        |
//   cfg     | in        | cfg_valid/cfg_ready, cfg_index, cfg_data      | one register write
//
// Cycles: a request beat is taken every cycle while loading; each one is sorted
// into the cell chain in the cycle it arrives, or dropped once the chain is full.
// A final request starts the schedule: the first sweep, the end cylinder, the
// jump and the second sweep for the requests left over; the sweeps rotate the
// cell chain past its head cell. No request is taken during the schedule.
// Stalls: every schedule step waits while the output register holds a beat that
// is not taken. Reset: synchronous; the chain empties and registers return to
// disk size 200, start 0, upward sweep. cfg_ready is always high.
module circular_scan_disk_scheduler_core #(
  parameter int MAX_REQUESTS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [csds_pkg::CYL_W-1:0]         in_request_cylinder,
  input  logic                               in_final_request,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [csds_pkg::CYL_W-1:0]         out_visited_cylinder,
  output logic [csds_pkg::MOVE_W-1:0]        out_movement_so_far,
  output logic                               out_schedule_done,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [csds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csds_pkg::CYL_W-1:0]         cfg_data
);

  localparam int CNT_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int LATE_W = $clog2(MAX_REQUESTS + 1);
  localparam int LAST   = MAX_REQUESTS - 1;

  typedef enum logic [2:0] {
    ST_LOAD,   // take requests into the chain
    ST_PASS1,  // first sweep over the chain
    ST_END,    // visit the end cylinder in the sweep direction
    ST_JUMP,   // return to the opposite end
    ST_PASS2   // serve the requests left over
  } state_t;

  // ---------------------------------------------------------------- config
  logic [csds_pkg::CYL_W-1:0] disk_size_r;
  logic [csds_pkg::CYL_W-1:0] start_pos_r;
  logic                       sweep_up_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_size_r <= csds_pkg::DISK_SIZE_RST;
      start_pos_r <= csds_pkg::START_POS_RST;
      sweep_up_r  <= csds_pkg::SWEEP_UP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csds_pkg::CFG_DISK_SIZE:      disk_size_r <= cfg_data;
        csds_pkg::CFG_START_POSITION: start_pos_r <= cfg_data;
        csds_pkg::CFG_SWEEP_UPWARD:   sweep_up_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // top cylinder, clamped request and clamped start
  logic [csds_pkg::CYL_W-1:0] top_cyl;
  logic [csds_pkg::CYL_W-1:0] req_clamped;
  logic [csds_pkg::CYL_W-1:0] start_clamped;

  assign top_cyl       = (disk_size_r == '0) ? '0 : disk_size_r - 1'b1;
  assign req_clamped   = (in_request_cylinder > top_cyl) ? top_cyl : in_request_cylinder;
  assign start_clamped = (start_pos_r > top_cyl) ? top_cyl : start_pos_r;

  // ---------------------------------------------------------------- state
  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            pass_cnt_r, pass_cnt_nxt;
  logic [LATE_W-1:0]           late_cnt_r, late_cnt_nxt;
  logic [csds_pkg::CYL_W-1:0]  head_r, head_nxt;
  logic [csds_pkg::MOVE_W-1:0] total_r, total_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [csds_pkg::CYL_W-1:0]  out_cyl_r, out_cyl_nxt;
  logic [csds_pkg::MOVE_W-1:0] out_move_r, out_move_nxt;
  logic                        out_done_r, out_done_nxt;

  csds_pkg::cell_op_t          cell_op;

  // ---------------------------------------------------------------- chain
  csds_pkg::cell_t cells  [MAX_REQUESTS];
  logic            lt_w   [MAX_REQUESTS];

  for (genvar gi = 0; gi < MAX_REQUESTS; gi++) begin : g_cell
    localparam int LEFT  = (gi == 0) ? LAST : gi - 1;
    localparam int RIGHT = (gi == LAST) ? 0 : gi + 1;

    csds_pkg::cell_t ins_prev;
    logic            ins_prev_lt;

    if (gi == 0) begin : g_first
      // the chain head always accepts a value that no cell sorts ahead of
      assign ins_prev.valid = 1'b1;
      assign ins_prev.val   = '0;
      assign ins_prev_lt    = 1'b0;
    end else begin : g_rest
      assign ins_prev    = cells[gi-1];
      assign ins_prev_lt = lt_w[gi-1];
    end

    csds_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .op_i          (cell_op),
      .new_val_i     (req_clamped),
      .ins_prev_i    (ins_prev),
      .ins_prev_lt_i (ins_prev_lt),
      .left_i        (cells[LEFT]),
      .right_i       (cells[RIGHT]),
      .cell_o        (cells[gi]),
      .lt_o          (lt_w[gi])
    );
  end

  // ascending order rotates out of cell 0, descending out of the last cell
  csds_pkg::cell_t head_cell;
  logic            head_early;
  logic            chain_full;

  assign head_cell  = sweep_up_r ? cells[0] : cells[LAST];
  assign head_early = sweep_up_r ? (head_cell.val >= start_clamped)
                                 : (head_cell.val <= start_clamped);
  assign chain_full = cells[LAST].valid;

  // ---------------------------------------------------------------- control
  logic                       in_fire;
  logic                       out_free;
  logic                       pass_last;
  logic                       emit;
  logic                       emit_jump;
  logic [csds_pkg::CYL_W-1:0] emit_cyl;
  logic                       emit_done;
  logic [csds_pkg::CYL_W-1:0] move_dist;
  csds_pkg::cell_op_t         rot_op;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign pass_last = (pass_cnt_r == CNT_W'(LAST));
  assign rot_op    = sweep_up_r ? csds_pkg::CELL_ROT_LEFT : csds_pkg::CELL_ROT_RIGHT;

  always_comb begin
    state_nxt    = state_r;
    pass_cnt_nxt = pass_cnt_r;
    late_cnt_nxt = late_cnt_r;
    cell_op      = csds_pkg::CELL_HOLD;
    emit         = 1'b0;
    emit_jump    = 1'b0;
    emit_cyl     = head_cell.val;
    emit_done    = 1'b0;

    case (state_r)
      ST_LOAD: begin
        // drop requests once the chain is full
        if (in_fire && !chain_full) begin
          cell_op = csds_pkg::CELL_INSERT;
        end
        if (in_fire && in_final_request) begin
          state_nxt    = ST_PASS1;
          pass_cnt_nxt = '0;
          late_cnt_nxt = '0;
        end
      end
      ST_PASS1: begin
        if (out_free) begin
          cell_op = rot_op;
          if (head_cell.valid && head_early) begin
            emit = 1'b1;
          end
          if (head_cell.valid && !head_early) begin
            late_cnt_nxt = late_cnt_r + 1'b1;
          end
          if (pass_last) begin
            state_nxt    = ST_END;
            pass_cnt_nxt = '0;
          end else begin
            pass_cnt_nxt = pass_cnt_r + 1'b1;
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_cyl  = sweep_up_r ? top_cyl : '0;
          state_nxt = ST_JUMP;
        end
      end
      ST_JUMP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_jump = 1'b1;
          emit_cyl  = sweep_up_r ? '0 : top_cyl;
          emit_done = (late_cnt_r == '0);
          if (late_cnt_r == '0) begin
            cell_op   = csds_pkg::CELL_CLEAR;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_PASS2;
          end
        end
      end
      ST_PASS2: begin
        if (out_free) begin
          cell_op      = rot_op;
          pass_cnt_nxt = pass_cnt_r + 1'b1;
          if (head_cell.valid && !head_early) begin
            emit         = 1'b1;
            emit_done    = (late_cnt_r == LATE_W'(1));
            late_cnt_nxt = late_cnt_r - 1'b1;
            if (late_cnt_r == LATE_W'(1)) begin
              // last leftover served: empty the chain for the next batch
              cell_op      = csds_pkg::CELL_CLEAR;
              state_nxt    = ST_LOAD;
              pass_cnt_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // head movement for the emitted visit
  assign move_dist = (emit_cyl >= head_r) ? emit_cyl - head_r : head_r - emit_cyl;

  always_comb begin
    head_nxt      = head_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_cyl_nxt   = out_cyl_r;
    out_move_nxt  = out_move_r;
    out_done_nxt  = out_done_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && in_final_request) begin
      // restart head and movement for this batch
      head_nxt  = start_clamped;
      total_nxt = '0;
    end
    if (emit) begin
      head_nxt      = emit_cyl;
      total_nxt     = emit_jump ? total_r + csds_pkg::MOVE_W'(top_cyl)
                                : total_r + csds_pkg::MOVE_W'(move_dist);
      out_valid_nxt = 1'b1;
      out_cyl_nxt   = emit_cyl;
      out_move_nxt  = total_nxt;
      out_done_nxt  = emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      pass_cnt_r  <= '0;
      late_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      head_r      <= csds_pkg::START_POS_RST;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      pass_cnt_r  <= pass_cnt_nxt;
      late_cnt_r  <= late_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
    end
    out_cyl_r  <= out_cyl_nxt;
    out_move_r <= out_move_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_visited_cylinder = out_cyl_r;
  assign out_movement_so_far  = out_move_r;
  assign out_schedule_done    = out_done_r;

endmodule

### tb/sv/tb_circular_scan_disk_scheduler_core.sv
// Self-checking testbench for the C-SCAN disk scheduler core.
`timescale 1ns / 100ps

module tb_circular_scan_disk_scheduler_core;

  localparam int MAX_REQ       = 16;
  // A full schedule rotates the chain twice plus the end and jump visits.
  localparam int SETTLE_CYCLES = 2 * MAX_REQ + 8;
  localparam int ITEM_TARGET   = 500;
  localparam int HOLD_OFF      = 300;
  localparam int TIMEOUT_NS    = 3_000_000;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [csds_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [csds_pkg::CYL_W-1:0]  cyl;
    logic [csds_pkg::MOVE_W-1:0] moved;
    logic                        done;
  } visit_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                           in_valid;
  logic                           in_ready;
  logic [csds_pkg::CYL_W-1:0]     in_request_cylinder;
  logic                           in_final_request;
  logic                           out_valid;
  logic                           out_ready;
  logic [csds_pkg::CYL_W-1:0]     out_visited_cylinder;
  logic [csds_pkg::MOVE_W-1:0]    out_movement_so_far;
  logic                           out_schedule_done;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [csds_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [csds_pkg::CYL_W-1:0]     cfg_data;

  // Register copies seen by the scheduler model, updated on each cfg beat.
  logic [csds_pkg::CYL_W-1:0]  disk_size_m;
  logic [csds_pkg::CYL_W-1:0]  start_pos_m;
  logic                        sweep_up_m;
  // Requests of the batch being loaded, already clamped.
  logic [csds_pkg::CYL_W-1:0]  stored_cyls[$];
  // Head and running movement while a schedule is worked out.
  logic [csds_pkg::CYL_W-1:0]  head_m;
  logic [csds_pkg::MOVE_W-1:0] moved_m;
  visit_t                      plan_q[$];
  // Visits the core still owes, oldest first.
  visit_t                      pending_visits[$];

  int fail_count  = 0;
  int items_sent  = 0;
  int hold_cycles = 0;
  bit sender_idle_on = 1'b1;
  bit recv_idle_on   = 1'b1;

  circular_scan_disk_scheduler_core #(
    .MAX_REQUESTS(MAX_REQ)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_request_cylinder (in_request_cylinder),
    .in_final_request    (in_final_request),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_visited_cylinder(out_visited_cylinder),
    .out_movement_so_far (out_movement_so_far),
    .out_schedule_done   (out_schedule_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler model
  // ---------------------------------------------------------------------------

  function automatic logic [csds_pkg::CYL_W-1:0] top_cylinder();
    return (disk_size_m == '0) ? '0 : disk_size_m - 1'b1;
  endfunction

  function automatic logic [csds_pkg::CYL_W-1:0] gap(input logic [csds_pkg::CYL_W-1:0] a,
                                                     input logic [csds_pkg::CYL_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Move the head to cyl at the given cost and record the visit.
  function automatic void log_visit(input logic [csds_pkg::CYL_W-1:0] cyl,
                                    input logic [csds_pkg::CYL_W-1:0] cost);
    visit_t v;
    moved_m = moved_m + cost;
    head_m  = cyl;
    v.cyl   = cyl;
    v.moved = moved_m;
    v.done  = 1'b0;
    plan_q.push_back(v);
  endfunction

  // Store one request; on the final one, append the whole C-SCAN order.
  task automatic cscan_order(input logic [csds_pkg::CYL_W-1:0] req, input logic fin);
    logic [csds_pkg::CYL_W-1:0] top, start, v;
    logic [csds_pkg::CYL_W-1:0] ordered[MAX_REQ];
    visit_t                     tail;
    int                         n, i, j;
    top = top_cylinder();
    // Clamp requests past the top cylinder; drop them once the store is full.
    if (req > top) req = top;
    if (stored_cyls.size() < MAX_REQ) stored_cyls.push_back(req);
    if (fin) begin
      n = stored_cyls.size();
      for (i = 0; i < n; i++) begin
        v = stored_cyls[i];
        j = i;
        while (j > 0 && ordered[j-1] > v) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = v;
      end
      start   = (start_pos_m > top) ? top : start_pos_m;
      head_m  = start;
      moved_m = '0;
      if (sweep_up_m) begin
        // Serve upward from the start, hit the top, wrap to 0, serve the rest.
        for (i = 0; i < n; i++)
          if (ordered[i] >= start) log_visit(ordered[i], gap(ordered[i], head_m));
        log_visit(top, gap(top, head_m));
        log_visit('0, top);
        for (i = 0; i < n; i++)
          if (ordered[i] < start) log_visit(ordered[i], gap(ordered[i], head_m));
      end else begin
        // Mirror image: serve downward, hit 0, wrap to the top, serve the rest.
        for (i = n - 1; i >= 0; i--)
          if (ordered[i] <= start) log_visit(ordered[i], gap(ordered[i], head_m));
        log_visit('0, gap('0, head_m));
        log_visit(top, top);
        for (i = n - 1; i >= 0; i--)
          if (ordered[i] > start) log_visit(ordered[i], gap(ordered[i], head_m));
      end
      tail = plan_q.pop_back();
      tail.done = 1'b1;
      plan_q.push_back(tail);
      while (plan_q.size() != 0) pending_visits.push_back(plan_q.pop_front());
      stored_cyls.delete();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: track cfg and request beats, check every visit beat
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_visits
    visit_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          csds_pkg::CFG_DISK_SIZE:      disk_size_m = cfg_data;
          csds_pkg::CFG_START_POSITION: start_pos_m = cfg_data;
          csds_pkg::CFG_SWEEP_UPWARD:   sweep_up_m  = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) cscan_order(in_request_cylinder, in_final_request);
      if (out_valid && out_ready) begin
        if (pending_visits.size() == 0) begin
          $display("%0t: unexpected visit beat, cylinder %0d movement %0d done %0b",
                   $time, out_visited_cylinder, out_movement_so_far, out_schedule_done);
          fail_count++;
        end else begin
          want = pending_visits.pop_front();
          if (out_visited_cylinder !== want.cyl) begin
            $display("%0t: visited_cylinder expected %0d actual %0d",
                     $time, want.cyl, out_visited_cylinder);
            fail_count++;
          end
          if (out_movement_so_far !== want.moved) begin
            $display("%0t: movement_so_far expected %0d actual %0d",
                     $time, want.moved, out_movement_so_far);
            fail_count++;
          end
          if (out_schedule_done !== want.done) begin
            $display("%0t: schedule_done expected %0b actual %0b",
                     $time, want.done, out_schedule_done);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= !(recv_idle_on && $urandom_range(0, 99) < 6);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until the core takes the beat.
  task automatic send_request(input logic [csds_pkg::CYL_W-1:0] cyl, input logic fin);
    while (sender_idle_on && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_request_cylinder <= cyl;
    in_final_request    <= fin;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
  endtask

  // Mostly in range, with ends, the start and raw 16-bit values mixed in.
  function automatic logic [csds_pkg::CYL_W-1:0] pick_cylinder();
    logic [csds_pkg::CYL_W-1:0] top;
    top = top_cylinder();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return top;
      2:       return csds_pkg::CYL_W'($urandom_range(0, 16'hFFFF));
      3:       return start_pos_m;
      default: return csds_pkg::CYL_W'($urandom_range(0, top));
    endcase
  endfunction

  task automatic send_batch(input int n);
    int i;
    for (i = 0; i < n; i++) send_request(pick_cylinder(), i == n - 1);
  endtask

  // Drop valid, wait out every owed visit, then let the core settle.
  task automatic drain_schedule();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_visits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic config_beat(input logic [csds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [csds_pkg::CYL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_config(input logic [csds_pkg::CYL_W-1:0] ds,
                            input logic [csds_pkg::CYL_W-1:0] sp,
                            input logic up);
    drain_schedule();
    config_beat(csds_pkg::CFG_DISK_SIZE, ds);
    config_beat(csds_pkg::CFG_START_POSITION, sp);
    config_beat(csds_pkg::CFG_SWEEP_UPWARD, {{(csds_pkg::CYL_W-1){1'b0}}, up});
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ends of the fields, clamping, duplicates, both sweeps, tiny and huge disks.
  task automatic test_directed();
    // Reset registers: 200 cylinders, start 0, upward.
    send_request(16'd50, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd199, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd120, 1'b1);
    // Request on the start and repeated lower requests.
    set_config(16'd200, 16'd100, 1'b1);
    send_request(16'd100, 1'b0);
    send_request(16'd30, 1'b0);
    send_request(16'd30, 1'b1);
    set_config(16'd200, 16'd100, 1'b0);
    send_request(16'd150, 1'b0);
    send_request(16'd100, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd180, 1'b1);
    // Largest disk; the unmapped index must leave the registers alone.
    set_config(16'hFFFF, 16'd65534, 1'b1);
    @(posedge clk);
    config_beat(CFG_UNMAPPED, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'd65534, 1'b1);
    // Zero, one and two cylinder disks, start past the top.
    set_config(16'd0, 16'hFFFF, 1'b0);
    send_request(16'd7, 1'b1);
    set_config(16'd1, 16'd5, 1'b1);
    send_request(16'd1, 1'b1);
    set_config(16'd2, 16'd1, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd1, 1'b1);
  endtask

  // Overfill the store; the extra requests are dropped.
  task automatic test_full_store();
    set_config(16'd1000, 16'd500, 1'b1);
    send_batch(20);
    send_batch(MAX_REQ + 1);
  endtask

  // Hold the receiver off while requests keep coming, so the input stalls.
  task automatic test_receiver_hold();
    set_config(16'd300, 16'd150, 1'b0);
    @(negedge clk);
    hold_cycles = HOLD_OFF;
    send_batch(8);
    send_batch(8);
    send_batch(8);
  endtask

  // Pause the sender until every owed visit is out, then resume.
  task automatic test_sender_pause();
    send_batch(6);
    drain_schedule();
    send_batch(5);
  endtask

  // Random register settings, each followed by several random batches.
  task automatic test_random_phases();
    int                         phase, b, nb;
    logic [csds_pkg::CYL_W-1:0] ds, sp;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       ds = 16'hFFFF;
        1:       ds = csds_pkg::CYL_W'($urandom_range(0, 2));
        2:       ds = csds_pkg::CYL_W'($urandom_range(0, 16'hFFFF));
        default: ds = csds_pkg::CYL_W'($urandom_range(3, 400));
      endcase
      case ($urandom_range(0, 9))
        0:       sp = 16'hFFFF;
        1:       sp = '0;
        2:       sp = csds_pkg::CYL_W'($urandom_range(0, 16'hFFFF));
        default: sp = csds_pkg::CYL_W'($urandom_range(0, ds));
      endcase
      // Run one phase with no idling on either side.
      sender_idle_on = (phase != 2);
      recv_idle_on   = (phase != 2);
      set_config(ds, sp, 1'($urandom_range(0, 1)));
      nb = $urandom_range(3, 8);
      for (b = 0; b < nb; b++)
        send_batch(($urandom_range(0, 5) == 0) ? $urandom_range(MAX_REQ + 1, 20)
                                               : $urandom_range(1, MAX_REQ));
      phase++;
    end
    sender_idle_on = 1'b1;
    recv_idle_on   = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_request_cylinder = '0;
    in_final_request    = 1'b0;
    out_ready           = 1'b0;
    cfg_valid           = 1'b0;
    cfg_index           = csds_pkg::CFG_DISK_SIZE;
    cfg_data            = '0;
    disk_size_m         = csds_pkg::DISK_SIZE_RST;
    start_pos_m         = csds_pkg::START_POS_RST;
    sweep_up_m          = csds_pkg::SWEEP_UP_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_store();
    test_receiver_hold();
    test_sender_pause();
    test_random_phases();

    drain_schedule();
    if (fail_count == 0 && pending_visits.size() == 0) begin
      $display("tb_circular_scan_disk_scheduler_core OK");
    end else begin
      $display("tb_circular_scan_disk_scheduler_core NOT OK");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_circular_scan_disk_scheduler_core NOT OK");
    $finish;
  end

endmodule
